// ===== hw/rtl/nnfd_pkg.sv =====
`timescale 1ns / 1ps

package nnfd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int FMT_W       = 3;
  localparam int OUT_COL_W   = 9;
  localparam int OUT_ROW_W   = 8;
  localparam int MAX_OUT_W   = 320;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd2;

  localparam logic [FMT_W-1:0] FMT_NONE    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_320X240 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_160X120 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_80X60   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_40X30   = 3'd4;
  localparam logic [FMT_W-1:0] FMT_20X15   = 3'd5;

  typedef struct packed {
    logic [31:0] source_pixel;
    logic        frame_start;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [FMT_W-1:0]      output_format;
    logic [CFG_DATA_W-1:0] source_width;
    logic [CFG_DATA_W-1:0] source_height;
  } cfg_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] dw;
    logic [OUT_ROW_W-1:0] dh;
  } out_size_t;

  function automatic out_size_t fmt_size(input logic [FMT_W-1:0] fmt);
    out_size_t s;
    unique case (fmt)
      FMT_320X240: begin s.dw = 9'd320; s.dh = 8'd240; end
      FMT_160X120: begin s.dw = 9'd160; s.dh = 8'd120; end
      FMT_80X60:   begin s.dw = 9'd80;  s.dh = 8'd60;  end
      FMT_40X30:   begin s.dw = 9'd40;  s.dh = 8'd30;  end
      FMT_20X15:   begin s.dw = 9'd20;  s.dh = 8'd15;  end
      default:     begin s.dw = 9'd0;   s.dh = 8'd0;   end
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/nnfd_stream_if.sv =====
`timescale 1ns / 1ps

interface nnfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nnfd_front.sv =====
`timescale 1ns / 1ps

module nnfd_front #(
  parameter int MAX_SOURCE_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  nnfd_pkg::cfg_t      cfg,
  nnfd_stream_if.sink         pixel_in,
  input  logic                q_full,
  output logic                push,
  output nnfd_pkg::out_item_t push_item
);
  import nnfd_pkg::*;

  localparam int ColW = $clog2(MAX_SOURCE_DIM);
  localparam int DimW = $clog2(MAX_SOURCE_DIM + 1);
  localparam int AccW = $clog2(MAX_OUT_W * MAX_SOURCE_DIM + 1);
  localparam int CmpW = AccW + 1;

  logic [ColW-1:0]      src_col, src_col_next, c_src_col;
  logic [ColW-1:0]      src_row, src_row_next, c_src_row;
  logic [OUT_COL_W-1:0] out_col, out_col_next, c_out_col;
  logic [OUT_ROW_W-1:0] out_row, out_row_next, c_out_row;
  logic [AccW-1:0]      col_target_acc, col_target_acc_next, c_col_target;
  logic [AccW-1:0]      col_scaled_pos, col_scaled_pos_next, c_col_scaled;
  logic [AccW-1:0]      row_target_acc, row_target_acc_next, c_row_target;
  logic [AccW-1:0]      row_scaled_pos, row_scaled_pos_next, c_row_scaled;

  out_size_t     sz;
  logic [DimW-1:0] w, h;
  logic          accept, fs, row_hit, col_hit, hit, row_end;

  assign pixel_in.ready = !q_full;
  assign accept = pixel_in.valid && pixel_in.ready;
  assign fs     = pixel_in.data.frame_start;
  assign sz     = fmt_size(cfg.output_format);

  // clamp source size to 1..MAX_SOURCE_DIM
  assign w = (cfg.source_width == '0) ? DimW'(1) :
             (32'(cfg.source_width) > 32'(MAX_SOURCE_DIM)) ? DimW'(MAX_SOURCE_DIM) :
             DimW'(cfg.source_width);
  assign h = (cfg.source_height == '0) ? DimW'(1) :
             (32'(cfg.source_height) > 32'(MAX_SOURCE_DIM)) ? DimW'(MAX_SOURCE_DIM) :
             DimW'(cfg.source_height);

  // frame start clears position before this pixel is classified
  assign c_src_col    = fs ? '0 : src_col;
  assign c_src_row    = fs ? '0 : src_row;
  assign c_out_col    = fs ? '0 : out_col;
  assign c_out_row    = fs ? '0 : out_row;
  assign c_col_target = fs ? '0 : col_target_acc;
  assign c_col_scaled = fs ? '0 : col_scaled_pos;
  assign c_row_target = fs ? '0 : row_target_acc;
  assign c_row_scaled = fs ? '0 : row_scaled_pos;

  assign row_hit = (c_out_row < sz.dh) &&
                   (CmpW'(c_row_target) < CmpW'(c_row_scaled) + CmpW'(sz.dh));
  assign col_hit = (c_out_col < sz.dw) &&
                   (CmpW'(c_col_target) < CmpW'(c_col_scaled) + CmpW'(sz.dw));
  assign hit     = row_hit && col_hit;
  assign row_end = ((DimW + 1)'(c_src_col) + (DimW + 1)'(1)) >= (DimW + 1)'(w);

  assign push                 = accept && hit;
  assign push_item.out_pixel  = pixel_in.data.source_pixel[7:0];
  assign push_item.frame_last =
      ((OUT_COL_W + 1)'(c_out_row) + (OUT_COL_W + 1)'(1) == (OUT_COL_W + 1)'(sz.dh)) &&
      ((OUT_COL_W + 1)'(c_out_col) + (OUT_COL_W + 1)'(1) == (OUT_COL_W + 1)'(sz.dw));

  always_comb begin
    src_col_next        = c_src_col;
    src_row_next        = c_src_row;
    out_col_next        = c_out_col;
    out_row_next        = c_out_row;
    col_target_acc_next = c_col_target;
    col_scaled_pos_next = c_col_scaled;
    row_target_acc_next = c_row_target;
    row_scaled_pos_next = c_row_scaled;
    if (row_end) begin
      if (row_hit) begin
        out_row_next        = c_out_row + OUT_ROW_W'(1);
        row_target_acc_next = c_row_target + AccW'(h);
      end
      src_col_next        = '0;
      out_col_next        = '0;
      col_target_acc_next = '0;
      col_scaled_pos_next = '0;
      if (c_src_row != ColW'(MAX_SOURCE_DIM - 1)) begin
        src_row_next        = c_src_row + ColW'(1);
        row_scaled_pos_next = c_row_scaled + AccW'(sz.dh);
      end
    end else begin
      if (hit) begin
        out_col_next        = c_out_col + OUT_COL_W'(1);
        col_target_acc_next = c_col_target + AccW'(w);
      end
      src_col_next        = c_src_col + ColW'(1);
      col_scaled_pos_next = c_col_scaled + AccW'(sz.dw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col        <= '0;
      src_row        <= '0;
      out_col        <= '0;
      out_row        <= '0;
      col_target_acc <= '0;
      col_scaled_pos <= '0;
      row_target_acc <= '0;
      row_scaled_pos <= '0;
    end else if (accept) begin
      src_col        <= src_col_next;
      src_row        <= src_row_next;
      out_col        <= out_col_next;
      out_row        <= out_row_next;
      col_target_acc <= col_target_acc_next;
      col_scaled_pos <= col_scaled_pos_next;
      row_target_acc <= row_target_acc_next;
      row_scaled_pos <= row_scaled_pos_next;
    end
  end

endmodule

// ===== hw/rtl/nnfd_queue.sv =====
`timescale 1ns / 1ps

module nnfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nnfd_pkg::out_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output nnfd_pkg::out_item_t pop_item
);
  import nnfd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  out_item_t       entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/nnfd_back.sv =====
`timescale 1ns / 1ps

module nnfd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  nnfd_pkg::out_item_t q_item,
  output logic                pop,
  nnfd_stream_if.source       pixel_out
);
  import nnfd_pkg::*;

  logic      out_valid;
  out_item_t out_data;

  // refill the output register when it is empty or its transfer completes
  assign pop             = !q_empty && (!out_valid || pixel_out.ready);
  assign pixel_out.valid = out_valid;
  assign pixel_out.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= q_item;
    end
  end

endmodule

// ===== hw/rtl/nearest_neighbor_frame_downscaler.sv =====
`timescale 1ns / 1ps

// Nearest-neighbor frame downscaler. Source pixels come in raster order, one
// per transfer, with frame_start on the first pixel of each frame; for every
// output pixel of the chosen format (320x240 down to 20x15, or none) the low
// byte of the nearest source pixel goes out, and frame_last marks the final
// one. The source must be at least as large as the output. Per source pixel
// the front classifier updates its column and row accumulators with one add
// and compare per axis, so a pixel can be accepted every cycle unless the
// queue is full. Results go via a two-entry queue and an output register,
// so a stalled sink holds back the source only once the queue is full.
// Configuration is written with cfg_we/cfg_index/cfg_data while idle.
module nearest_neighbor_frame_downscaler #(
  parameter int MAX_SOURCE_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nnfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nnfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  nnfd_stream_if.sink                         pixel_in,
  nnfd_stream_if.source                       pixel_out
);
  import nnfd_pkg::*;

  cfg_t      cfg;
  logic      push, q_full, pop, q_empty;
  out_item_t push_item, q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format <= FMT_NONE;
      cfg.source_width  <= CFG_DATA_W'(320);
      cfg.source_height <= CFG_DATA_W'(240);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_FORMAT: cfg.output_format <= cfg_data[FMT_W-1:0];
        CFG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: cfg.source_height <= cfg_data;
        default:           cfg <= cfg;
      endcase
    end
  end

  nnfd_front #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel_in  (pixel_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  nnfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  nnfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .pixel_out (pixel_out)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import nnfd_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam logic [FMT_W-1:0] FMT_SPARE_6 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_SPARE_7 = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  nnfd_stream_if #(.payload_t(src_item_t)) pixel_in ();
  nnfd_stream_if #(.payload_t(out_item_t)) pixel_out ();

  nearest_neighbor_frame_downscaler #(.MAX_SOURCE_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out)
  );

  // scaler model state
  logic [FMT_W-1:0]      fmt_sel;
  logic [CFG_DATA_W-1:0] width_cfg;
  logic [CFG_DATA_W-1:0] height_cfg;
  logic [11:0]           col_in;
  logic [11:0]           row_in;
  logic [8:0]            col_out;
  logic [7:0]            row_out;
  logic [20:0]           col_goal;
  logic [20:0]           col_pos;
  logic [20:0]           row_goal;
  logic [20:0]           row_pos;

  out_item_t scaled_pixel_q[$];
  int        failures;
  int        burst_left;
  int        gap_max;
  logic [31:0] stall_bits;
  int        stall_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [12:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 13'd1;
    if (v > 13'(MAX_DIM)) return 13'(MAX_DIM);
    return v;
  endfunction

  task automatic downscale_pixel(input src_item_t item);
    logic [8:0]  dw;
    logic [7:0]  dh;
    logic [12:0] w;
    logic [12:0] h;
    logic        row_hit;
    logic        col_hit;
    out_item_t   res;
    if (item.frame_start) begin
      col_in = '0; row_in = '0; col_out = '0; row_out = '0;
      col_goal = '0; col_pos = '0; row_goal = '0; row_pos = '0;
    end
    case (fmt_sel)
      FMT_320X240: begin dw = 9'd320; dh = 8'd240; end
      FMT_160X120: begin dw = 9'd160; dh = 8'd120; end
      FMT_80X60:   begin dw = 9'd80;  dh = 8'd60;  end
      FMT_40X30:   begin dw = 9'd40;  dh = 8'd30;  end
      FMT_20X15:   begin dw = 9'd20;  dh = 8'd15;  end
      default:     begin dw = 9'd0;   dh = 8'd0;   end
    endcase
    w = clamp_dim(width_cfg);
    h = clamp_dim(height_cfg);
    row_hit = (row_out < dh) && (22'(row_goal) < 22'(row_pos) + 22'(dh));
    col_hit = (col_out < dw) && (22'(col_goal) < 22'(col_pos) + 22'(dw));
    if (row_hit && col_hit) begin
      res.out_pixel  = item.source_pixel[7:0];
      res.frame_last = (9'(row_out) + 9'd1 == 9'(dh)) && (10'(col_out) + 10'd1 == 10'(dw));
      scaled_pixel_q.push_back(res);
      col_out  = col_out + 9'd1;
      col_goal = col_goal + 21'(w);
    end
    if (13'(col_in) + 13'd1 >= w) begin
      if (row_hit) begin
        row_out  = row_out + 8'd1;
        row_goal = row_goal + 21'(h);
      end
      col_in = '0; col_out = '0; col_goal = '0; col_pos = '0;
      if (13'(row_in) + 13'd1 < 13'(MAX_DIM)) begin
        row_in  = row_in + 12'd1;
        row_pos = row_pos + 21'(dh);
      end
    end else begin
      col_in  = col_in + 12'd1;
      col_pos = col_pos + 21'(dw);
    end
  endtask

  task automatic send_pixel(input logic [31:0] px, input logic fs);
    src_item_t item;
    int        gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        pixel_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item.source_pixel = px;
    item.frame_start  = fs;
    pixel_in.valid <= 1'b1;
    pixel_in.data  <= item;
    @(posedge clk);
    while (!pixel_in.ready) @(posedge clk);
    downscale_pixel(item);
  endtask

  task automatic send_frame(input int len, input bit with_start, input int noise);
    logic fs;
    for (int i = 0; i < len; i++) begin
      fs = (i == 0) && with_start;
      if (noise != 0 && $urandom_range(0, noise - 1) == 0) fs = 1'b1;
      send_pixel($urandom, fs);
    end
  endtask

  task automatic wait_idle();
    int waited;
    pixel_in.valid <= 1'b0;
    waited = 0;
    while (scaled_pixel_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (scaled_pixel_q.size() != 0) begin
      failures++;
      $error("out_pixel: expected %0d more results, actual none", scaled_pixel_q.size());
      scaled_pixel_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    pixel_in.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OUTPUT_FORMAT: fmt_sel    = val[FMT_W-1:0];
      CFG_SOURCE_WIDTH:  width_cfg  = val;
      CFG_SOURCE_HEIGHT: height_cfg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // counters run from reset state without any frame_start
  task automatic test_start_without_frame_start();
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_20X15));
    write_reg(CFG_SOURCE_WIDTH, 13'd40);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hA5A5_A55A, 1'b0);
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'hFFFF_FF00, 1'b0);
    send_pixel(32'h5A5A_5AA5, 1'b0);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_idle();
  endtask

  task automatic test_no_format();
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_NONE));
    send_frame(2, 1'b1, 0);
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_SPARE_6));
    send_frame(2, 1'b1, 0);
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_SPARE_7));
    send_frame(2, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_small_source();
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_320X240));
    write_reg(CFG_SOURCE_WIDTH, 13'd3);
    write_reg(CFG_SOURCE_HEIGHT, 13'd2);
    send_frame(6, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_each_format();
    logic [FMT_W-1:0] fmts[3];
    fmts = '{FMT_160X120, FMT_80X60, FMT_40X30};
    write_reg(CFG_SOURCE_WIDTH, 13'd320);
    write_reg(CFG_SOURCE_HEIGHT, 13'd240);
    foreach (fmts[i]) begin
      write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(fmts[i]));
      send_frame(2, 1'b1, 0);
      wait_idle();
    end
  endtask

  // full frames, pixels past the marked one, and a restart mid-frame
  task automatic test_full_frames();
    gap_max = 4;
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_20X15));
    write_reg(CFG_SOURCE_WIDTH, 13'd20);
    write_reg(CFG_SOURCE_HEIGHT, 13'd15);
    send_frame(310, 1'b1, 0);
    wait_idle();
    write_reg(CFG_SOURCE_WIDTH, 13'd24);
    write_reg(CFG_SOURCE_HEIGHT, 13'd17);
    send_frame(40, 1'b1, 0);
    send_frame(24 * 17, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_clamped_sizes();
    gap_max = 2;
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_320X240));
    write_reg(CFG_SOURCE_WIDTH, 13'h1FFF);
    write_reg(CFG_SOURCE_HEIGHT, 13'd0);
    send_frame(100, 1'b1, 0);
    wait_idle();
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_160X120));
    write_reg(CFG_SOURCE_WIDTH, 13'(MAX_DIM));
    write_reg(CFG_SOURCE_HEIGHT, 13'(MAX_DIM));
    send_frame(100, 1'b1, 0);
    wait_idle();
  endtask

  // one-pixel rows with the height clamped to its top value
  task automatic test_tall_source();
    gap_max = 0;
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_20X15));
    write_reg(CFG_SOURCE_WIDTH, 13'd0);
    write_reg(CFG_SOURCE_HEIGHT, 13'h1FFF);
    send_frame(300, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_mid_frame_change();
    gap_max = 3;
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_80X60));
    write_reg(CFG_SOURCE_WIDTH, 13'd100);
    write_reg(CFG_SOURCE_HEIGHT, 13'd70);
    send_frame(100, 1'b1, 0);
    wait_idle();
    write_reg(CFG_OUTPUT_FORMAT, CFG_DATA_W'(FMT_40X30));
    write_reg(CFG_SOURCE_WIDTH, 13'd60);
    send_frame(100, 1'b0, 0);
    wait_idle();
  endtask

  task automatic test_random();
    int               sent;
    int               len;
    int               area;
    logic [FMT_W-1:0] fmt;
    logic [9:0]       hi;
    logic [12:0]      w;
    logic [12:0]      h;
    sent = 0;
    while (sent < 170) begin
      wait_idle();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      fmt = FMT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) fmt = FMT_20X15;
      case ($urandom_range(0, 7))
        0: w = 13'd0;
        1: w = 13'h1FFF;
        2: w = 13'($urandom_range(320, MAX_DIM));
        3: w = 13'($urandom_range(1, 8191));
        default: w = (fmt == FMT_20X15) ? 13'($urandom_range(20, 34))
                                        : 13'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
        0: h = 13'd0;
        1: h = 13'h1FFF;
        2: h = 13'($urandom_range(240, MAX_DIM));
        3: h = 13'($urandom_range(1, 8191));
        default: h = (fmt == FMT_20X15) ? 13'($urandom_range(15, 22))
                                        : 13'($urandom_range(1, 30));
      endcase
      hi = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0;
      if ($urandom_range(0, 3) != 0) write_reg(CFG_OUTPUT_FORMAT, {hi, fmt});
      if ($urandom_range(0, 3) != 0) write_reg(CFG_SOURCE_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_SOURCE_HEIGHT, h);
      area = int'(clamp_dim(width_cfg)) * int'(clamp_dim(height_cfg));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0: len = $urandom_range(1, 60);
          1: len = area + $urandom_range(1, 40);
          default: len = area;
        endcase
        if (len > 700) len = $urandom_range(20, 400);
        if (len > 170 - sent) len = 170 - sent;
        send_frame(len, $urandom_range(0, 5) != 0, ($urandom_range(0, 3) == 0) ? 60 : 0);
        sent += len;
      end
    end
  endtask

  initial begin
    out_item_t want;
    out_item_t got;
    forever begin
      @(posedge clk);
      if (!rst && pixel_out.valid && pixel_out.ready) begin
        got = pixel_out.data;
        if (scaled_pixel_q.size() == 0) begin
          failures++;
          $error("out_pixel: expected none, actual 0x%02h", got.out_pixel);
        end else begin
          want = scaled_pixel_q.pop_front();
          if (got.out_pixel !== want.out_pixel) begin
            failures++;
            $error("out_pixel: expected 0x%02h, actual 0x%02h", want.out_pixel, got.out_pixel);
          end
          if (got.frame_last !== want.frame_last) begin
            failures++;
            $error("frame_last: expected %0b, actual %0b", want.frame_last, got.frame_last);
          end
        end
      end
    end
  end

  // sink stalls follow a rotating bit pattern, reshuffled whenever its hold count runs out
  initial begin
    pixel_out.ready = 1'b0;
    stall_hold = 0;
    stall_bits = '1;
    forever begin
      @(posedge clk);
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_bits = '1;
          1: stall_bits = $urandom | $urandom;
          2: stall_bits = $urandom;
          default: stall_bits = $urandom & $urandom;
        endcase
        stall_bits[0] = 1'b1;
      end
      stall_hold--;
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      pixel_out.ready <= stall_bits[0];
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_OUTPUT_FORMAT;
    cfg_data       = '0;
    pixel_in.valid = 1'b0;
    pixel_in.data  = '0;
    failures       = 0;
    burst_left     = 0;
    gap_max        = 3;
    fmt_sel        = FMT_NONE;
    width_cfg      = 13'd320;
    height_cfg     = 13'd240;
    col_in = '0; row_in = '0; col_out = '0; row_out = '0;
    col_goal = '0; col_pos = '0; row_goal = '0; row_pos = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_start_without_frame_start();
    test_no_format();
    test_small_source();
    test_each_format();
    test_full_frames();
    test_clamped_sizes();
    test_tall_source();
    test_mid_frame_change();
    test_random();

    wait_idle();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
